### rtl/q15_pid_controller_assert.svh
// Assertion macros shared by the controller RTL.
// Each macro expects clk and rst in scope.
`ifndef Q15_PID_CONTROLLER_ASSERT_SVH
`define Q15_PID_CONTROLLER_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define Q15PID_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define Q15PID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/q15pid_pkg.sv
`default_nettype none
package q15pid_pkg;

  // Q15 constants
  localparam logic signed [15:0] Q15_ONE  = 16'sh7FFF;
  localparam logic signed [15:0] ZERO_Q15 = 16'sh0000;
  localparam logic signed [15:0] Q15_MIN  = 16'sh8000;
  localparam logic signed [15:0] Q15_MAX  = 16'sh7FFF;
  localparam int unsigned        FRAC_BITS = 15;

  localparam logic signed [31:0] Q31_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q31_MAX = 32'sh7FFF_FFFF;

  // APB port
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  // Register map, index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_GAIN_PROP   = 3'd0,
    REG_GAIN_INTEG  = 3'd1,
    REG_GAIN_DERIV  = 3'd2,
    REG_DRIVE_LOW   = 3'd3,
    REG_DRIVE_HIGH  = 3'd4,
    REG_ACCUM_LOW   = 3'd5,
    REG_ACCUM_HIGH  = 3'd6,
    REG_DERIV_ALPHA = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] gain_prop;
    logic signed [15:0] gain_integ;
    logic signed [15:0] gain_deriv;
    logic signed [15:0] drive_low;
    logic signed [15:0] drive_high;
    logic signed [15:0] accum_low;
    logic signed [15:0] accum_high;
    logic        [14:0] deriv_alpha;
  } cfg_t;

  // Microcode fields
  localparam int unsigned STEP_W = 4;

  typedef enum logic [2:0] {
    MA_GAIN_PROP,
    MA_GAIN_INTEG,
    MA_GAIN_DERIV,
    MA_KEEP,
    MA_ALPHA
  } mul_a_t;

  typedef enum logic [2:0] {
    MB_ERR,
    MB_INTEG_IN,
    MB_MEAS_DIFF,
    MB_LAST_DERIV,
    MB_DERIV
  } mul_b_t;

  typedef enum logic [2:0] {
    MD_NONE,
    MD_PROP,
    MD_INTEG,
    MD_DERIV,
    MD_FILT
  } mul_dst_t;

  typedef enum logic [2:0] {
    ALU_NONE,
    ALU_ERR,       // err  = target - measured
    ALU_MEAS_DIFF, // dm   = last_measured - measured
    ALU_PROP_INTEG,// acc  = p + i
    ALU_FILT_SUM,  // d    = t + d
    ALU_TOTAL      // acc  = acc + d
  } alu_op_t;

  typedef struct packed {
    mul_a_t              ma;
    mul_b_t              mb;
    mul_dst_t            md;
    alu_op_t             alu;
    logic                skip_filt;
    logic [STEP_W-1:0]   target;
    logic                fin;
  } ctrl_word_t;

  typedef struct packed {
    logic       load;
    logic       exec;
    logic       finish;
    ctrl_word_t cw;
  } seq_ctl_t;

  localparam logic [STEP_W-1:0] STEP_ERR    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_PROP   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_INTEG  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_DERIV  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_KEEP   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_ALPHA  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_FSUM   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_TOTAL  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_FIN    = 4'd8;

  // Saturate a 17-bit value to Q15
  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v[16] != v[15]) begin
      r = v[16] ? Q15_MIN : Q15_MAX;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Control store
  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    w = '{ma: MA_GAIN_PROP, mb: MB_ERR, md: MD_NONE, alu: ALU_NONE,
          skip_filt: 1'b0, target: STEP_ERR, fin: 1'b0};
    unique case (step)
      STEP_ERR: begin
        w.alu = ALU_ERR;
      end
      STEP_PROP: begin
        w.ma = MA_GAIN_PROP;  w.mb = MB_ERR;       w.md = MD_PROP;
        w.alu = ALU_MEAS_DIFF;
      end
      STEP_INTEG: begin
        w.ma = MA_GAIN_INTEG; w.mb = MB_INTEG_IN;  w.md = MD_INTEG;
      end
      STEP_DERIV: begin
        w.ma = MA_GAIN_DERIV; w.mb = MB_MEAS_DIFF; w.md = MD_DERIV;
        w.alu = ALU_PROP_INTEG;
        w.skip_filt = 1'b1;   w.target = STEP_TOTAL;
      end
      STEP_KEEP: begin
        w.ma = MA_KEEP;       w.mb = MB_LAST_DERIV; w.md = MD_FILT;
      end
      STEP_ALPHA: begin
        w.ma = MA_ALPHA;      w.mb = MB_DERIV;     w.md = MD_DERIV;
      end
      STEP_FSUM: begin
        w.alu = ALU_FILT_SUM;
      end
      STEP_TOTAL: begin
        w.alu = ALU_TOTAL;
      end
      default: begin
        w.fin = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

### rtl/q15pid_if.sv
`default_nettype none
// Sample channel: setpoint and feedback
interface q15pid_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] target;
  logic signed [15:0] measured;

  modport source (output valid, output target, output measured, input ready);
  modport sink   (input valid, input target, input measured, output ready);
endinterface

// Result channel: drive value and clamp flag
interface q15pid_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] drive;
  logic               clamped;

  modport source (output valid, output drive, output clamped, input ready);
  modport sink   (input valid, input drive, input clamped, output ready);
endinterface
`default_nettype wire

### rtl/q15pid_regs.sv
`default_nettype none
module q15pid_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [q15pid_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [q15pid_pkg::PDATA_W-1:0]      pwdata,
  output logic      [q15pid_pkg::PDATA_W-1:0]      prdata,
  output logic                                     pready,
  output q15pid_pkg::cfg_t                         cfg,
  output logic                                     clr
);

  q15pid_pkg::reg_idx_t idx;
  logic                 wr;

  assign idx    = q15pid_pkg::reg_idx_t'(paddr[q15pid_pkg::PADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  // any write restarts the loop state
  assign clr    = wr;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_prop   <= q15pid_pkg::Q15_ONE;
      cfg.gain_integ  <= q15pid_pkg::ZERO_Q15;
      cfg.gain_deriv  <= q15pid_pkg::ZERO_Q15;
      cfg.drive_low   <= q15pid_pkg::Q15_MIN;
      cfg.drive_high  <= q15pid_pkg::Q15_MAX;
      cfg.accum_low   <= q15pid_pkg::Q15_MIN;
      cfg.accum_high  <= q15pid_pkg::Q15_MAX;
      cfg.deriv_alpha <= '0;
    end else if (wr) begin
      unique case (idx)
        q15pid_pkg::REG_GAIN_PROP:   cfg.gain_prop   <= pwdata[15:0];
        q15pid_pkg::REG_GAIN_INTEG:  cfg.gain_integ  <= pwdata[15:0];
        q15pid_pkg::REG_GAIN_DERIV:  cfg.gain_deriv  <= pwdata[15:0];
        q15pid_pkg::REG_DRIVE_LOW:   cfg.drive_low   <= pwdata[15:0];
        q15pid_pkg::REG_DRIVE_HIGH:  cfg.drive_high  <= pwdata[15:0];
        q15pid_pkg::REG_ACCUM_LOW:   cfg.accum_low   <= pwdata[15:0];
        q15pid_pkg::REG_ACCUM_HIGH:  cfg.accum_high  <= pwdata[15:0];
        q15pid_pkg::REG_DERIV_ALPHA: cfg.deriv_alpha <= pwdata[14:0];
      endcase
    end
  end

  // readback, signed fields sign-extended, alpha zero-extended
  always_comb begin
    unique case (idx)
      q15pid_pkg::REG_GAIN_PROP:   prdata = 32'(cfg.gain_prop);
      q15pid_pkg::REG_GAIN_INTEG:  prdata = 32'(cfg.gain_integ);
      q15pid_pkg::REG_GAIN_DERIV:  prdata = 32'(cfg.gain_deriv);
      q15pid_pkg::REG_DRIVE_LOW:   prdata = 32'(cfg.drive_low);
      q15pid_pkg::REG_DRIVE_HIGH:  prdata = 32'(cfg.drive_high);
      q15pid_pkg::REG_ACCUM_LOW:   prdata = 32'(cfg.accum_low);
      q15pid_pkg::REG_ACCUM_HIGH:  prdata = 32'(cfg.accum_high);
      q15pid_pkg::REG_DERIV_ALPHA: prdata = {17'd0, cfg.deriv_alpha};
    endcase
  end

endmodule
`default_nettype wire

### rtl/q15pid_seq.sv
`default_nettype none
module q15pid_seq (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire logic                 alpha_zero,
  output q15pid_pkg::seq_ctl_t      ctl
);

  logic                              busy;
  logic [q15pid_pkg::STEP_W-1:0]     step;
  logic [q15pid_pkg::STEP_W-1:0]     step_next;
  q15pid_pkg::ctrl_word_t            cw;
  logic                              accept;
  logic                              finish;

  assign cw       = q15pid_pkg::ucode(step);
  assign in_ready = !busy;
  assign accept   = in_valid && !busy;
  // retire only when the output register is free or being drained
  assign finish   = busy && cw.fin && (!out_valid || out_ready);

  assign ctl.load   = accept;
  assign ctl.exec   = busy;
  assign ctl.finish = finish;
  assign ctl.cw     = cw;

  // pick the next step: jump past the filter when it is off
  always_comb begin
    if (cw.fin) begin
      step_next = step;
    end else if (cw.skip_filt && alpha_zero) begin
      step_next = cw.target;
    end else begin
      step_next = step + 1'b1;
    end
  end

  // step counter and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= q15pid_pkg::STEP_ERR;
    end else if (accept) begin
      busy <= 1'b1;
      step <= q15pid_pkg::STEP_ERR;
    end else if (busy) begin
      if (finish) begin
        busy <= 1'b0;
      end
      step <= step_next;
    end
  end

  // output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

### rtl/q15pid_dp.sv
`default_nettype none
module q15pid_dp (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire q15pid_pkg::cfg_t      cfg,
  input  wire logic                  clr,
  input  wire q15pid_pkg::seq_ctl_t  ctl,
  input  wire logic signed [15:0]    target,
  input  wire logic signed [15:0]    measured,
  output logic signed [15:0]         drive,
  output logic                       clamped
);

  // working registers
  logic signed [15:0] tgt, meas, err, dm, p, i, d, t, acc;
  // loop state
  logic signed [31:0] error_sum;
  logic signed [15:0] last_measured, last_deriv;

  logic signed [15:0] mul_a, mul_b, mul_q, integ_in, keep;
  logic signed [31:0] prod;
  logic signed [15:0] alu_a, alu_b, alu_q;
  logic               alu_sub;

  logic signed [15:0] drv_hi, drv;
  logic               sat, integrate, err_pos, err_neg;
  logic signed [32:0] sum_wide;
  logic signed [31:0] sum_sat, es_int, es_hi, es_lo, lim_hi, lim_lo;

  assign integ_in = q15pid_pkg::sat16(error_sum[31:15]);
  assign keep     = {1'b0, ~cfg.deriv_alpha};

  // multiplier operand routing
  always_comb begin
    unique case (ctl.cw.ma)
      q15pid_pkg::MA_GAIN_PROP:  mul_a = cfg.gain_prop;
      q15pid_pkg::MA_GAIN_INTEG: mul_a = cfg.gain_integ;
      q15pid_pkg::MA_GAIN_DERIV: mul_a = cfg.gain_deriv;
      q15pid_pkg::MA_KEEP:       mul_a = keep;
      q15pid_pkg::MA_ALPHA:      mul_a = {1'b0, cfg.deriv_alpha};
      default:                   mul_a = '0;
    endcase
    unique case (ctl.cw.mb)
      q15pid_pkg::MB_ERR:        mul_b = err;
      q15pid_pkg::MB_INTEG_IN:   mul_b = integ_in;
      q15pid_pkg::MB_MEAS_DIFF:  mul_b = dm;
      q15pid_pkg::MB_LAST_DERIV: mul_b = last_deriv;
      q15pid_pkg::MB_DERIV:      mul_b = d;
      default:                   mul_b = '0;
    endcase
  end

  // shared Q15 multiply: truncate by 15, saturate to 16 bits
  assign prod  = mul_a * mul_b;
  assign mul_q = q15pid_pkg::sat16(prod[31:15]);

  // shared saturating adder
  always_comb begin
    alu_a   = acc;
    alu_b   = d;
    alu_sub = 1'b0;
    unique case (ctl.cw.alu)
      q15pid_pkg::ALU_ERR: begin
        alu_a = tgt; alu_b = meas; alu_sub = 1'b1;
      end
      q15pid_pkg::ALU_MEAS_DIFF: begin
        alu_a = last_measured; alu_b = meas; alu_sub = 1'b1;
      end
      q15pid_pkg::ALU_PROP_INTEG: begin
        alu_a = p; alu_b = i;
      end
      q15pid_pkg::ALU_FILT_SUM: begin
        alu_a = t; alu_b = d;
      end
      q15pid_pkg::ALU_TOTAL: begin
        alu_a = acc; alu_b = d;
      end
      default: begin
        alu_a = acc; alu_b = d;
      end
    endcase
  end

  assign alu_q = alu_sub ? q15pid_pkg::sat16(17'(alu_a) - 17'(alu_b))
                         : q15pid_pkg::sat16(17'(alu_a) + 17'(alu_b));

  // write back per micro-step
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      tgt  <= target;
      meas <= measured;
    end
    if (ctl.exec) begin
      unique case (ctl.cw.md)
        q15pid_pkg::MD_PROP:  p <= mul_q;
        q15pid_pkg::MD_INTEG: i <= mul_q;
        q15pid_pkg::MD_DERIV: d <= mul_q;
        q15pid_pkg::MD_FILT:  t <= mul_q;
        default: ;
      endcase
      unique case (ctl.cw.alu)
        q15pid_pkg::ALU_ERR:        err <= alu_q;
        q15pid_pkg::ALU_MEAS_DIFF:  dm  <= alu_q;
        q15pid_pkg::ALU_PROP_INTEG: acc <= alu_q;
        q15pid_pkg::ALU_FILT_SUM:   d   <= alu_q;
        q15pid_pkg::ALU_TOTAL:      acc <= alu_q;
        default: ;
      endcase
    end
  end

  // output clamp, low limit applied last
  assign drv_hi  = (acc > cfg.drive_high) ? cfg.drive_high : acc;
  assign drv     = (drv_hi < cfg.drive_low) ? cfg.drive_low : drv_hi;
  assign sat     = (acc > cfg.drive_high) || (acc < cfg.drive_low);
  assign err_pos = !err[15] && (err != q15pid_pkg::ZERO_Q15);
  assign err_neg = err[15];
  // hold the integrator when the error pushes further into the clamp
  assign integrate = !sat || !(((acc > drv) && err_pos) || ((acc < drv) && err_neg));

  // integrator update with 32-bit saturation, then limit clamp
  assign sum_wide = 33'(error_sum) + $signed({{2{err[15]}}, err, 15'd0});
  assign sum_sat  = (sum_wide[32] != sum_wide[31])
                    ? (sum_wide[32] ? q15pid_pkg::Q31_MIN : q15pid_pkg::Q31_MAX)
                    : sum_wide[31:0];
  assign es_int   = integrate ? sum_sat : error_sum;
  assign lim_hi   = $signed({cfg.accum_high[15], cfg.accum_high, 15'd0});
  assign lim_lo   = $signed({cfg.accum_low[15], cfg.accum_low, 15'd0});
  assign es_hi    = (es_int > lim_hi) ? lim_hi : es_int;
  assign es_lo    = (es_hi < lim_lo) ? lim_lo : es_hi;

  // loop state
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      error_sum     <= '0;
      last_measured <= '0;
      last_deriv    <= '0;
    end else if (ctl.finish) begin
      error_sum     <= es_lo;
      last_measured <= meas;
      last_deriv    <= d;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      drive   <= drv;
      clamped <= sat;
    end
  end

endmodule
`default_nettype wire

### rtl/q15_pid_controller.sv
// Channel  | Dir | Payload                 | Beat when
// ---------+-----+-------------------------+------------------------------
// sample   | in  | target, measured (Q15)  | sample.valid && sample.ready
// result   | out | drive (Q15), clamped    | result.valid && result.ready
// apb      | in  | 8 regs at 4*i, 32b data | psel && penable && pwrite
//
// One item runs 6 micro-steps with the derivative filter off, 9 with it on,
// all sharing a single 16x16 multiplier and one saturating adder; a new
// sample is taken in the cycle after the previous one retires.
// Reset (rst, synchronous) loads register defaults and zeroes the loop state.
// A result waits in the output register; if it is still held at the last
// micro-step, the sequencer stalls there until the result beat goes out.
`default_nettype none
`include "q15_pid_controller_assert.svh"
module q15_pid_controller (
  input  wire logic                              clk,
  input  wire logic                              rst,
  q15pid_in_if.sink                              sample,
  q15pid_out_if.source                           result,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [q15pid_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [q15pid_pkg::PDATA_W-1:0]    pwdata,
  output logic      [q15pid_pkg::PDATA_W-1:0]    prdata,
  output logic                                   pready
);

  q15pid_pkg::cfg_t     cfg;
  q15pid_pkg::seq_ctl_t ctl;
  logic                 clr;
  logic                 alpha_zero;

  assign alpha_zero = (cfg.deriv_alpha == '0);

  q15pid_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .clr     (clr)
  );

  q15pid_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (sample.valid),
    .in_ready   (sample.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .alpha_zero (alpha_zero),
    .ctl        (ctl)
  );

  q15pid_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .clr      (clr),
    .ctl      (ctl),
    .target   (sample.target),
    .measured (sample.measured),
    .drive    (result.drive),
    .clamped  (result.clamped)
  );

  // block goes busy once a sample is taken
  `Q15PID_ASSERT_NEXT(a_busy_after_take, sample.valid && sample.ready, !sample.ready,
    "sample accepted while a step is in flight")

  // a clamped result sits on one of the drive limits
  `Q15PID_ASSERT_SAME(a_clamp_on_limit, result.valid && result.clamped,
    (result.drive == cfg.drive_high) || (result.drive == cfg.drive_low),
    "clamped drive off both limits")

  // with ordered limits the drive stays inside them
  `Q15PID_ASSERT_SAME(a_drive_in_range,
    result.valid && ($signed(cfg.drive_low) <= $signed(cfg.drive_high)),
    ($signed(result.drive) >= $signed(cfg.drive_low)) &&
    ($signed(result.drive) <= $signed(cfg.drive_high)),
    "drive outside its limits")

endmodule
`default_nettype wire

### test/testbench.sv
module testbench;

  // One expected beat on the result channel
  typedef struct {
    logic signed [15:0] drive;
    logic               clamped;
  } drive_beat_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [q15pid_pkg::PADDR_W-1:0] paddr;
  logic [q15pid_pkg::PDATA_W-1:0] pwdata;
  logic [q15pid_pkg::PDATA_W-1:0] prdata;
  logic pready;

  q15pid_in_if  sample_ch();
  q15pid_out_if result_ch();

  q15_pid_controller i_dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Controller copy: register settings and loop state
  q15pid_pkg::cfg_t model_cfg;
  int   integ_q30;
  int   prev_meas;
  int   prev_deriv;

  drive_beat_t expected_drive_q[$];

  int  errors;
  int  samples_sent;
  int  settings_applied;
  int  clamp_seen;
  bit  steady;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    #(8 * 400000);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int clip_q15(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  // Q15 product: arithmetic shift of the full product, then saturate
  function automatic int q15_mul(int a, int b);
    int prod;
    prod = a * b;
    return clip_q15(prod >>> q15pid_pkg::FRAC_BITS);
  endfunction

  function automatic q15pid_pkg::cfg_t default_cfg();
    q15pid_pkg::cfg_t c;
    c = '{gain_prop: q15pid_pkg::Q15_ONE, gain_integ: q15pid_pkg::ZERO_Q15,
          gain_deriv: q15pid_pkg::ZERO_Q15, drive_low: q15pid_pkg::Q15_MIN,
          drive_high: q15pid_pkg::Q15_MAX, accum_low: q15pid_pkg::Q15_MIN,
          accum_high: q15pid_pkg::Q15_MAX, deriv_alpha: 15'd0};
    return c;
  endfunction

  function automatic void clear_loop_state();
    integ_q30  = 0;
    prev_meas  = 0;
    prev_deriv = 0;
  endfunction

  // Mirror one register write; any write clears the loop state
  function automatic void apply_reg(q15pid_pkg::reg_idx_t idx, logic [31:0] word);
    case (idx)
      q15pid_pkg::REG_GAIN_PROP:   model_cfg.gain_prop   = word[15:0];
      q15pid_pkg::REG_GAIN_INTEG:  model_cfg.gain_integ  = word[15:0];
      q15pid_pkg::REG_GAIN_DERIV:  model_cfg.gain_deriv  = word[15:0];
      q15pid_pkg::REG_DRIVE_LOW:   model_cfg.drive_low   = word[15:0];
      q15pid_pkg::REG_DRIVE_HIGH:  model_cfg.drive_high  = word[15:0];
      q15pid_pkg::REG_ACCUM_LOW:   model_cfg.accum_low   = word[15:0];
      q15pid_pkg::REG_ACCUM_HIGH:  model_cfg.accum_high  = word[15:0];
      q15pid_pkg::REG_DERIV_ALPHA: model_cfg.deriv_alpha = word[14:0];
      default: ;
    endcase
    clear_loop_state();
  endfunction

  // One control step: PID terms, output clamp, conditional integration
  function automatic drive_beat_t step_controller(int tgt, int meas);
    int err, p, d, alpha, keep, integ, unsat, drv, diff, lo, hi, lim_lo, lim_hi;
    longint sum;
    bit sat, hold;
    drive_beat_t r;
    alpha = int'(model_cfg.deriv_alpha);
    lo    = int'(model_cfg.drive_low);
    hi    = int'(model_cfg.drive_high);
    err = clip_q15(longint'(tgt) - meas);
    p   = q15_mul(model_cfg.gain_prop, err);
    d   = q15_mul(model_cfg.gain_deriv, clip_q15(longint'(prev_meas) - meas));
    if (alpha != 0) begin
      keep = clip_q15(longint'(32767) - alpha);
      d = clip_q15(longint'(q15_mul(keep, prev_deriv)) + q15_mul(alpha, d));
    end
    integ = q15_mul(model_cfg.gain_integ,
                    clip_q15(integ_q30 >>> q15pid_pkg::FRAC_BITS));
    unsat = clip_q15(longint'(clip_q15(longint'(p) + integ)) + d);
    // Low limit applied last, so it wins when the limits are inverted
    drv = unsat;
    if (drv > hi) drv = hi;
    if (drv < lo) drv = lo;
    sat = (unsat > hi) || (unsat < lo);
    // Hold the integrator while the error pushes further into the clamp
    hold = 1'b0;
    if (sat) begin
      diff = clip_q15(longint'(unsat) - drv);
      hold = (diff > 0 && err > 0) || (diff < 0 && err < 0);
    end
    if (!hold) begin
      sum = longint'(integ_q30) + longint'(err) * 32768;
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      integ_q30 = int'(sum);
    end
    lim_hi = int'(model_cfg.accum_high) * 32768;
    lim_lo = int'(model_cfg.accum_low) * 32768;
    if (integ_q30 > lim_hi) integ_q30 = lim_hi;
    if (integ_q30 < lim_lo) integ_q30 = lim_lo;
    prev_meas  = meas;
    prev_deriv = d;
    r.drive   = drv[15:0];
    r.clamped = sat;
    return r;
  endfunction

  // Random Q15 value, biased toward the extremes and small magnitudes
  function automatic int pick_q15();
    logic signed [15:0] r;
    case ($urandom_range(0, 5))
      0: return q15pid_pkg::Q15_MIN;
      1: return q15pid_pkg::Q15_MAX;
      2: return 0;
      3: return int'($urandom_range(0, 510)) - 255;
      default: begin
        r = 16'($urandom());
        return r;
      end
    endcase
  endfunction

  // Stop sending and wait until every expected beat has come back
  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    while (expected_drive_q.size() != 0) @(posedge clk);
  endtask

  // Write the masked registers over APB once the block is idle
  task automatic set_config(q15pid_pkg::cfg_t c, logic [7:0] mask);
    q15pid_pkg::reg_idx_t idx;
    logic [31:0] word;
    logic [15:0] field;
    wait_drained();
    for (int i = 0; i < 8; i++) begin
      if (mask[i]) begin
        idx = q15pid_pkg::reg_idx_t'(i);
        case (idx)
          q15pid_pkg::REG_GAIN_PROP:   field = c.gain_prop;
          q15pid_pkg::REG_GAIN_INTEG:  field = c.gain_integ;
          q15pid_pkg::REG_GAIN_DERIV:  field = c.gain_deriv;
          q15pid_pkg::REG_DRIVE_LOW:   field = c.drive_low;
          q15pid_pkg::REG_DRIVE_HIGH:  field = c.drive_high;
          q15pid_pkg::REG_ACCUM_LOW:   field = c.accum_low;
          q15pid_pkg::REG_ACCUM_HIGH:  field = c.accum_high;
          default:         field = {1'($urandom_range(0, 1)), c.deriv_alpha};
        endcase
        // Upper data bits carry noise; the block takes the low bits only
        word = $urandom();
        word[15:0] = field;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        apply_reg(idx, word);
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_applied++;
  endtask

  // Send one sample beat and queue its predicted result
  task automatic send_sample(int tgt, int meas);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid    <= 1'b1;
    sample_ch.target   <= tgt[15:0];
    sample_ch.measured <= meas[15:0];
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    expected_drive_q.push_back(step_controller(tgt, meas));
    samples_sent++;
  endtask

  // Result side: random stall before each beat
  initial begin
    int stall;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    drive_beat_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_drive_q.size() == 0) begin
        $error("result beat with no sample pending: drive %0d", result_ch.drive);
        errors++;
      end else begin
        want = expected_drive_q.pop_front();
        if (want.clamped) clamp_seen++;
        if (result_ch.drive !== want.drive) begin
          $error("drive: expected %0d, got %0d", want.drive, result_ch.drive);
          errors++;
        end
        if (result_ch.clamped !== want.clamped) begin
          $error("clamped: expected %0b, got %0b", want.clamped, result_ch.clamped);
          errors++;
        end
      end
    end
  end

  // Reset defaults and full-scale error in both directions
  task automatic test_field_extremes();
    send_sample(0, 0);
    send_sample(32767, -32768);
    send_sample(-32768, 32767);
    send_sample(32767, 32767);
    send_sample(-32768, -32768);
    send_sample(-1, 1);
    send_sample(16384, -16384);
  endtask

  // Narrow drive window: integrator holds while pushed into the clamp
  task automatic test_clamp_and_windup();
    q15pid_pkg::cfg_t c;
    c = '{gain_prop: 16'sd16384, gain_integ: q15pid_pkg::Q15_MAX,
          gain_deriv: q15pid_pkg::ZERO_Q15,
          drive_low: -16'sd4096, drive_high: 16'sd4096, accum_low: q15pid_pkg::Q15_MIN,
          accum_high: q15pid_pkg::Q15_MAX, deriv_alpha: 15'd0};
    set_config(c, 8'hFF);
    steady = 1'b1;
    repeat (4) send_sample(20000, 0);
    repeat (2) send_sample(-20000, 0);
    repeat (2) send_sample(100, 0);
    steady = 1'b0;
    // Inverted drive and accumulator limits: low limit wins
    c.gain_integ = 16'sd16384;
    c.drive_low  = 16'sd1000;
    c.drive_high = -16'sd1000;
    c.accum_low  = 16'sd100;
    c.accum_high = -16'sd100;
    set_config(c, 8'hFF);
    send_sample(500, 0);
    send_sample(-500, 0);
    send_sample(0, 0);
  endtask

  // Derivative on measurement, filter at full and minimum coefficient
  task automatic test_deriv_filter();
    q15pid_pkg::cfg_t c;
    c = '{gain_prop: q15pid_pkg::ZERO_Q15, gain_integ: q15pid_pkg::ZERO_Q15,
          gain_deriv: q15pid_pkg::Q15_MIN,
          drive_low: q15pid_pkg::Q15_MIN, drive_high: q15pid_pkg::Q15_MAX,
          accum_low: q15pid_pkg::Q15_MIN,
          accum_high: q15pid_pkg::Q15_MAX, deriv_alpha: 15'h7FFF};
    set_config(c, 8'hFF);
    send_sample(0, 32767);
    send_sample(0, -32768);
    send_sample(0, 0);
    // A single write clears the filter history too
    c.deriv_alpha = 15'd1;
    set_config(c, 8'h80);
    send_sample(0, 20000);
    send_sample(0, -20000);
    send_sample(0, -20000);
    // Coefficient zero bypasses the filter
    c.gain_deriv  = q15pid_pkg::Q15_MAX;
    c.deriv_alpha = 15'd0;
    set_config(c, 8'h84);
    send_sample(0, 12345);
    send_sample(0, -12345);
  endtask

  function automatic q15pid_pkg::cfg_t random_config(int phase);
    q15pid_pkg::cfg_t c;
    int lo, hi, t;
    if (phase == 0) begin
      c = '{gain_prop: q15pid_pkg::Q15_MAX, gain_integ: q15pid_pkg::Q15_MAX,
            gain_deriv: q15pid_pkg::Q15_MAX,
            drive_low: q15pid_pkg::Q15_MIN, drive_high: q15pid_pkg::Q15_MAX,
            accum_low: q15pid_pkg::Q15_MIN,
            accum_high: q15pid_pkg::Q15_MAX, deriv_alpha: 15'h7FFF};
      return c;
    end
    if (phase == 1) begin
      c = '{gain_prop: q15pid_pkg::Q15_MIN, gain_integ: q15pid_pkg::Q15_MIN,
            gain_deriv: q15pid_pkg::Q15_MIN,
            drive_low: q15pid_pkg::Q15_MIN, drive_high: q15pid_pkg::Q15_MAX,
            accum_low: q15pid_pkg::Q15_MIN,
            accum_high: q15pid_pkg::Q15_MAX, deriv_alpha: 15'd1};
      return c;
    end
    c.gain_prop  = 16'(pick_q15());
    c.gain_integ = 16'(pick_q15());
    c.gain_deriv = 16'(pick_q15());
    // Limits mostly ordered, now and then inverted
    lo = pick_q15();
    hi = pick_q15();
    if (lo > hi && $urandom_range(0, 5) != 0) begin
      t = lo; lo = hi; hi = t;
    end
    c.drive_low  = 16'(lo);
    c.drive_high = 16'(hi);
    lo = pick_q15();
    hi = pick_q15();
    if (lo > hi && $urandom_range(0, 5) != 0) begin
      t = lo; lo = hi; hi = t;
    end
    c.accum_low  = 16'(lo);
    c.accum_high = 16'(hi);
    case ($urandom_range(0, 3))
      0: c.deriv_alpha = 15'd0;
      1: c.deriv_alpha = 15'h7FFF;
      default: c.deriv_alpha = 15'($urandom_range(1, 32767));
    endcase
    return c;
  endfunction

  // Closed-loop style sequences with random noise mixed in
  task automatic test_random_loops();
    q15pid_pkg::cfg_t c;
    int sp, fb, div;
    for (int phase = 0; phase < 12; phase++) begin
      c = random_config(phase);
      set_config(c, 8'hFF);
      steady = (phase % 4 == 3);
      sp = pick_q15();
      fb = pick_q15();
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          send_sample(pick_q15(), pick_q15());
        end else begin
          if ($urandom_range(0, 19) == 0) sp = pick_q15();
          div = 1 << $urandom_range(1, 4);
          fb = clip_q15(longint'(fb) + (sp - fb) / div + int'($urandom_range(0, 64)) - 32);
          send_sample(sp, fb);
        end
        if ($urandom_range(0, 49) == 0) wait_drained();
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    errors           = 0;
    samples_sent     = 0;
    settings_applied = 0;
    clamp_seen       = 0;
    steady           = 1'b0;
    model_cfg        = default_cfg();
    clear_loop_state();
    rst                <= 1'b1;
    sample_ch.valid    <= 1'b0;
    sample_ch.target   <= '0;
    sample_ch.measured <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_clamp_and_windup();
    test_deriv_filter();
    test_random_loops();

    // Drain, then watch for stray beats
    wait_drained();
    repeat (24) @(posedge clk);
    $display("covered %0d samples across %0d register settings, %0d clamped results",
             samples_sent, settings_applied, clamp_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/q15pid_pkg.sv
rtl/q15pid_if.sv
rtl/q15pid_regs.sv
rtl/q15pid_seq.sv
rtl/q15pid_dp.sv
rtl/q15_pid_controller.sv
test/testbench.sv
